>>> rtl/core/vnacc_pkg.sv
// ----------------------------------------------------------------------------
// vnacc_pkg
// shared types and constants of the vertex normal accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package vnacc_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_VERTEX = 2'd0,
    OP_ADD_TRIANGLE = 2'd1,
    OP_READ_NORMAL  = 2'd2,
    OP_CLEAR        = 2'd3
  } op_e;

  localparam int SUM_W = 64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam int NORM_W = 16;
  localparam int QUOT_W = 17;

endpackage

`default_nettype wire

>>> rtl/core/vnacc_ram.sv
// ----------------------------------------------------------------------------
// vnacc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module vnacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// area weighted vertex normals: position store, per-vertex normal sums and a
// normalising read path built on one shared multiplier
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | op, index, coords, corners
//  out     | output    | out_valid_o / out_stall_i | normal xyz, degenerate
//
//  write vertex: written in the accepting cycle; add triangle: the accepting cycle,
//  then reads of the three corner positions, the edges, the cross products and a
//  read and write of each corner's sum row, set by the single sum ram port and the multiplier
//  read normal: the time from one accept to the next is set by the
//  one-bit-a-cycle square root, the 17 step division lanes and the
//  normalising shifts
//  clear, and the pass after reset: one row a cycle
//  the input stalls while a transaction is in work; a result waits in the
//  output register and a further read only stalls at its very end
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [9:0]                    vertex_index_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  wire logic [9:0]                    corner_a_i,
  input  wire logic [9:0]                    corner_b_i,
  input  wire logic [9:0]                    corner_c_i,
  input  wire logic                          reversed_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [vnacc_pkg::NORM_W-1:0] normal_x_o,
  output logic signed [vnacc_pkg::NORM_W-1:0] normal_y_o,
  output logic signed [vnacc_pkg::NORM_W-1:0] normal_z_o,
  output logic                               degenerate_o
);

  import vnacc_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int PW    = 3 * COORD_WIDTH;
  localparam int RW    = 3 * SUM_W;
  // multiplier operand width: edges and 31 bit magnitudes both fit
  localparam int MW    = (COORD_WIDTH + 1 > 32) ? COORD_WIDTH + 1 : 32;
  localparam int DW    = 2 * MW + 1;
  localparam logic signed [DW-1:0] SMAX_X = DW'(SUM_MAX);
  localparam logic signed [DW-1:0] SMIN_X = DW'(SUM_MIN);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_VERTICES - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TRI_RD, S_TRI_EDGE, S_TRI_MUL, S_ACC_RD, S_ACC_WR,
    S_RN_RD, S_RN_MAG, S_RN_MAX, S_RN_NORM, S_RN_SQ, S_RN_SQRT, S_RN_DIVSET,
    S_RN_DIV, S_RN_OUT
  } state_e;

  state_e        state_q;
  logic [4:0]    cnt_q;
  logic [1:0]    vc_q;
  logic [AW-1:0] clr_q;
  logic          deg_q;

  logic accept;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // corner swap and range checks
  logic [9:0] ca, cb;
  logic       tri_ok, vi_ok;
  assign ca     = reversed_i ? corner_b_i : corner_a_i;
  assign cb     = reversed_i ? corner_a_i : corner_b_i;
  assign tri_ok = (32'(ca) < MAX_VERTICES) && (32'(cb) < MAX_VERTICES)
               && (32'(corner_c_i) < MAX_VERTICES);
  assign vi_ok  = 32'(vertex_index_i) < MAX_VERTICES;

  // datapath registers
  logic [AW-1:0]            corner_q [3];
  logic [AW-1:0]            vi_q;
  logic signed [COORD_WIDTH-1:0] pa_q [3], pb_q [3], pc_q [3];
  logic signed [MW-1:0]     e1_q [3], e2_q [3];
  logic signed [2*MW-1:0]   prod_q;
  logic signed [DW-1:0]     cacc_q;
  logic signed [SUM_W-1:0]  fn_q [3];
  logic                     neg_q [3];
  logic [SUM_W-1:0]         m_q [3];
  logic [SUM_W-1:0]         mx_q;
  logic [SUM_W-1:0]         sq_q, n_q, r_q, bit_q;
  logic [48:0]              rem_q [3];
  logic [48:0]              dsh_q;
  logic [QUOT_W-1:0]        quo_q [3];

  // ram ports
  logic          pos_we;
  logic [AW-1:0] pos_raddr;
  logic [PW-1:0] pos_rdata;
  logic          sum_we;
  logic [AW-1:0] sum_waddr, sum_raddr;
  logic [RW-1:0] sum_wdata, sum_rdata;

  assign pos_we = accept && (op_e'(op_i) == OP_WRITE_VERTEX) && vi_ok;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pos_raddr = corner_q[0];
      2'd1:    pos_raddr = corner_q[1];
      default: pos_raddr = corner_q[2];
    endcase
  end

  vnacc_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (AW'(vertex_index_i)),
    .wdata_i ({coord_z_i, coord_y_i, coord_x_i}),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // saturating update of one sum row
  logic signed [SUM_W-1:0] old_sum [3];
  logic signed [SUM_W-1:0] new_sum [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [SUM_W:0] s;
      old_sum[k] = sum_rdata[k*SUM_W +: SUM_W];
      s = {old_sum[k][SUM_W-1], old_sum[k]} + {fn_q[k][SUM_W-1], fn_q[k]};
      if (s[SUM_W] != s[SUM_W-1]) begin
        new_sum[k] = s[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        new_sum[k] = s[SUM_W-1:0];
      end
    end
  end

  assign sum_we    = (state_q == S_CLEAR) || (state_q == S_ACC_WR);
  assign sum_waddr = (state_q == S_CLEAR) ? clr_q : corner_q[vc_q];
  assign sum_wdata = (state_q == S_CLEAR) ? '0 : {new_sum[2], new_sum[1], new_sum[0]};
  assign sum_raddr = (state_q == S_RN_RD) ? vi_q : corner_q[vc_q];

  vnacc_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  // shared multiplier operand select
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_RN_SQ) begin
      case (cnt_q[1:0])
        2'd0:    mul_a = $signed({{(MW-31){1'b0}}, m_q[0][30:0]});
        2'd1:    mul_a = $signed({{(MW-31){1'b0}}, m_q[1][30:0]});
        default: mul_a = $signed({{(MW-31){1'b0}}, m_q[2][30:0]});
      endcase
      mul_b = mul_a;
    end else begin
      case (cnt_q[2:0])
        3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
        3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
        3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
        3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
        3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
        default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // cross term difference, saturated to the sum range
  logic signed [DW-1:0]    cdiff;
  logic signed [SUM_W-1:0] csat;
  assign cdiff = cacc_q - DW'(prod_q);
  assign csat  = (cdiff > SMAX_X) ? SUM_MAX :
                 (cdiff < SMIN_X) ? SUM_MIN : cdiff[SUM_W-1:0];

  // result clamp of one lane
  function automatic logic signed [NORM_W-1:0] clamp_q(input logic neg,
                                                       input logic [QUOT_W-1:0] q);
    logic signed [NORM_W-1:0] r;
    if (neg) begin
      r = (q > QUOT_W'(32768)) ? -16'sd32768 : NORM_W'(-$signed({1'b0, q}));
    end else begin
      r = (q > QUOT_W'(32767)) ? 16'sd32767 : NORM_W'(q);
    end
    return r;
  endfunction

  // control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      vc_q         <= '0;
      clr_q        <= '0;
      deg_q        <= 1'b0;
      out_valid_o  <= 1'b0;
      normal_x_o   <= '0;
      normal_y_o   <= '0;
      normal_z_o   <= '0;
      degenerate_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && (state_q != S_RN_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_q == LAST_ROW) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          cnt_q <= '0;
          vc_q  <= '0;
          if (accept) begin
            case (op_e'(op_i))
              OP_ADD_TRIANGLE: if (tri_ok) state_q <= S_TRI_RD;
              OP_READ_NORMAL: begin
                // an index out of range answers degenerate at once
                deg_q   <= !vi_ok;
                state_q <= vi_ok ? S_RN_RD : S_RN_OUT;
              end
              OP_CLEAR: state_q <= S_CLEAR;
              default:  state_q <= S_IDLE;
            endcase
          end
        end
        S_TRI_RD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd3) state_q <= S_TRI_EDGE;
        end
        S_TRI_EDGE: begin
          cnt_q   <= '0;
          state_q <= S_TRI_MUL;
        end
        S_TRI_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd6) state_q <= S_ACC_RD;
        end
        S_ACC_RD: state_q <= S_ACC_WR;
        S_ACC_WR: begin
          vc_q <= vc_q + 1'b1;
          state_q <= (vc_q == 2'd2) ? S_IDLE : S_ACC_RD;
        end
        S_RN_RD:  state_q <= S_RN_MAG;
        S_RN_MAG: state_q <= S_RN_MAX;
        S_RN_MAX: state_q <= S_RN_NORM;
        S_RN_NORM: begin
          cnt_q <= '0;
          if (mx_q == '0) begin
            deg_q   <= 1'b1;
            state_q <= S_RN_OUT;
          end else if (mx_q[SUM_W-1:31] == '0 && mx_q[30]) begin
            state_q <= S_RN_SQ;
          end
        end
        S_RN_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd3) state_q <= S_RN_SQRT;
        end
        S_RN_SQRT: if (bit_q == '0) state_q <= S_RN_DIVSET;
        S_RN_DIVSET: begin
          cnt_q   <= '0;
          state_q <= S_RN_DIV;
        end
        S_RN_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(QUOT_W - 1)) state_q <= S_RN_OUT;
        end
        S_RN_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o  <= 1'b1;
            degenerate_o <= deg_q;
            normal_x_o   <= deg_q ? '0 : clamp_q(neg_q[0], quo_q[0]);
            normal_y_o   <= deg_q ? '0 : clamp_q(neg_q[1], quo_q[1]);
            normal_z_o   <= deg_q ? '0 : clamp_q(neg_q[2], quo_q[2]);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        corner_q[0] <= AW'(ca);
        corner_q[1] <= AW'(cb);
        corner_q[2] <= AW'(corner_c_i);
        vi_q        <= AW'(vertex_index_i);
      end
      S_TRI_RD: begin
        for (int k = 0; k < 3; k++) begin
          case (cnt_q[1:0])
            2'd1:    pa_q[k] <= pos_rdata[k*COORD_WIDTH +: COORD_WIDTH];
            2'd2:    pb_q[k] <= pos_rdata[k*COORD_WIDTH +: COORD_WIDTH];
            2'd3:    pc_q[k] <= pos_rdata[k*COORD_WIDTH +: COORD_WIDTH];
            default: ;
          endcase
        end
      end
      S_TRI_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= MW'(pb_q[k]) - MW'(pa_q[k]);
          e2_q[k] <= MW'(pc_q[k]) - MW'(pa_q[k]);
        end
      end
      S_TRI_MUL: begin
        prod_q <= mul_p;
        if (cnt_q != '0) begin
          if (cnt_q[0]) begin
            cacc_q <= DW'(prod_q);
          end else begin
            fn_q[cnt_q[2:1] - 2'd1] <= csat;
          end
        end
      end
      S_RN_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= sum_rdata[k*SUM_W + SUM_W - 1];
          m_q[k]   <= sum_rdata[k*SUM_W + SUM_W - 1] ?
                      SUM_W'(0) - sum_rdata[k*SUM_W +: SUM_W] :
                      sum_rdata[k*SUM_W +: SUM_W];
        end
      end
      S_RN_MAX: begin
        mx_q <= (m_q[0] > m_q[1]) ?
                ((m_q[0] > m_q[2]) ? m_q[0] : m_q[2]) :
                ((m_q[1] > m_q[2]) ? m_q[1] : m_q[2]);
      end
      S_RN_NORM: begin
        // coarse then fine steps bring the largest magnitude into [2^30, 2^31)
        sq_q  <= '0;
        if (mx_q[SUM_W-1:39] != '0) begin
          mx_q <= mx_q >> 8;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 8;
        end else if (mx_q[SUM_W-1:31] != '0) begin
          mx_q <= mx_q >> 1;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end else if (mx_q[SUM_W-1:22] == '0) begin
          mx_q <= mx_q << 8;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 8;
        end else if (!mx_q[30]) begin
          mx_q <= mx_q << 1;
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
        end
      end
      S_RN_SQ: begin
        prod_q <= mul_p;
        if (cnt_q != '0) sq_q <= sq_q + prod_q[SUM_W-1:0];
        if (cnt_q == 5'd3) begin
          n_q   <= sq_q + prod_q[SUM_W-1:0];
          r_q   <= '0;
          bit_q <= SUM_W'(1) << 62;
        end
      end
      S_RN_SQRT: begin
        if (bit_q != '0) begin
          if (n_q >= r_q + bit_q) begin
            n_q <= n_q - (r_q + bit_q);
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      S_RN_DIVSET: begin
        // numerator mag*2^16 + len, divisor 2*len aligned to the top quotient bit
        dsh_q <= {r_q[31:0], 17'd0};
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= {2'b00, m_q[k][30:0], 16'd0} + {17'd0, r_q[31:0]};
          quo_q[k] <= '0;
        end
      end
      S_RN_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (rem_q[k] >= dsh_q) begin
            rem_q[k] <= rem_q[k] - dsh_q;
            quo_q[k] <= {quo_q[k][QUOT_W-2:0], 1'b1};
          end else begin
            quo_q[k] <= {quo_q[k][QUOT_W-2:0], 1'b0};
          end
        end
        dsh_q <= dsh_q >> 1;
      end
      default: ;
    endcase
  end

  // a read transaction never leaves the input open the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_e'(op_i) == OP_READ_NORMAL) |=> in_stall_o)
    else $error("input open right after a read normal transaction");

  // a degenerate result carries zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero components");

  // squaring only starts on normalised magnitudes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RN_SQ |-> mx_q[SUM_W-1:31] == '0 && mx_q[30])
    else $error("magnitudes not normalised before squaring");

  // the square root of a normalised sum lies in [2^30, 2^32)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RN_DIVSET |-> r_q[SUM_W-1:32] == '0 && (r_q[31] || r_q[30]))
    else $error("square root out of range");

  // a finished result never overwrites one still held by a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RN_OUT && out_valid_o && out_stall_i |=> state_q == S_RN_OUT)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
